### design/trajectory_interpolator_3axis_macros.svh
// assertion macros for the trajectory interpolator
`ifndef TRAJECTORY_INTERPOLATOR_3AXIS_MACROS_SVH
`define TRAJECTORY_INTERPOLATOR_3AXIS_MACROS_SVH

// same-cycle implication
`define TRI3_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TRI3_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/tri3_pkg.sv
`default_nettype none
package tri3_pkg;
   localparam int POS_W   = 32;
   localparam int DLT_W   = 33;
   localparam int NUM_W   = 19;
   localparam int DEN_W   = 19;
   localparam int PRD_W   = 53;
   localparam int QUO_W   = 34;
   localparam int SUM_W   = 35;
   localparam int STEP_W  = 7;
   localparam int CNT_W   = 6;
   localparam int MAX_STEPS = 64;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_TIME  = 2'd1;
   localparam logic [1:0] ST_TYPE  = 2'd2;

   localparam logic [1:0] MODE_LIN = 2'd0;
   localparam logic [1:0] MODE_CUB = 2'd1;

   typedef struct packed {
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic signed [POS_W-1:0] target_z;
      logic [STEP_W-1:0]       duration_steps;
      logic [1:0]              mode;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [1:0]              status;
      logic                    last;
   } rsp_type;
endpackage
`default_nettype wire

### design/tri3_div.sv
`default_nettype none
module tri3_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tri3_pkg::PRD_W-1:0]    dividend,
   input  wire logic [tri3_pkg::DEN_W-1:0]    divisor,
   output logic                               done,
   output logic                               busy,
   output logic [tri3_pkg::QUO_W-1:0]         quotient
);
   import tri3_pkg::*;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[QUO_W-1]};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[PRD_W-1:QUO_W];
         dvd_in  = dividend[QUO_W-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = DEN_W'(trial - {1'b0, divisor});
            dvd_in = {dvd_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            dvd_in = {dvd_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(QUO_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign busy     = busy_ff;
   assign quotient = dvd_ff;
endmodule
`default_nettype wire

### design/trajectory_interpolator_3axis.sv
`default_nettype none
`include "trajectory_interpolator_3axis_macros.svh"
// Three-axis move interpolator. A request of n steps (n above 64 counts as 64) yields n
// position transactions in Q16.16, linear or cubic, ending at the target, which becomes
// the new current position; a zero duration or an unknown mode yields one error
// transaction with the position unchanged. One request is handled at a time and
// req_ready is low meanwhile. For each point the step numerator is formed (with more
// multiplier steps in cubic mode) and the three axes are then divided in turn by the
// 34-step bit-serial divider, using the single multiplier shared by all axes; the
// block waits before each transaction while the output is held off.
module trajectory_interpolator_3axis (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire tri3_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output tri3_pkg::rsp_type       rsp_data
);
   import tri3_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEN1 = 4'd1;
   localparam logic [3:0] S_DEN2 = 4'd2;
   localparam logic [3:0] S_DEN3 = 4'd3;
   localparam logic [3:0] S_NUM1 = 4'd4;
   localparam logic [3:0] S_NUM2 = 4'd5;
   localparam logic [3:0] S_NUM3 = 4'd6;
   localparam logic [3:0] S_MUL  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_DIVW = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;
   localparam logic [3:0] S_ERR  = 4'd11;

   logic [3:0]              state_ff, state_in;
   logic signed [POS_W-1:0] cur_ff [3];
   logic signed [POS_W-1:0] cur_in [3];
   logic signed [POS_W-1:0] pt_ff  [3];
   logic signed [POS_W-1:0] pt_in  [3];
   logic signed [DLT_W-1:0] dlt_ff [3];
   logic signed [DLT_W-1:0] dlt_in [3];
   logic [STEP_W-1:0]       n_ff, n_in, i_ff, i_in;
   logic                    cub_ff, cub_in;
   logic [1:0]              err_ff, err_in;
   logic [1:0]              axis_ff, axis_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic                    neg_ff, neg_in;
   logic signed [PRD_W-1:0] mul_ff;
   logic signed [DLT_W-1:0] mul_a;
   logic [NUM_W-1:0]        mul_b;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    div_start;
   logic                    div_done;
   logic                    div_busy;
   logic [QUO_W-1:0]        quo;
   logic [PRD_W-1:0]        mag;
   logic signed [SUM_W-1:0] sum;
   logic signed [POS_W-1:0] sat;
   logic                    out_free;
   logic [STEP_W-1:0]       n_req;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign mag = (mul_ff < 0) ? PRD_W'(-mul_ff) + PRD_W'(den_ff >> 1)
                             : PRD_W'(mul_ff) + PRD_W'(den_ff >> 1);

   tri3_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  (den_ff),
      .done     (div_done),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_comb begin
      sum = SUM_W'(cur_ff[axis_ff]) +
            (neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
      if (sum > SUM_W'(32'sh7fffffff))
         sat = 32'sh7fffffff;
      else if (sum < -SUM_W'(33'sh080000000))
         sat = 32'sh80000000;
      else
         sat = sum[POS_W-1:0];
   end

   assign n_req = (req_data.duration_steps > STEP_W'(MAX_STEPS)) ?
                  STEP_W'(MAX_STEPS) : req_data.duration_steps;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pt_in        = pt_ff;
      dlt_in       = dlt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      cub_in       = cub_ff;
      err_in       = err_ff;
      axis_in      = axis_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in      = n_req;
               i_in      = STEP_W'(1);
               axis_in   = '0;
               cub_in    = (req_data.mode == MODE_CUB);
               dlt_in[0] = DLT_W'(req_data.target_x) - DLT_W'(cur_ff[0]);
               dlt_in[1] = DLT_W'(req_data.target_y) - DLT_W'(cur_ff[1]);
               dlt_in[2] = DLT_W'(req_data.target_z) - DLT_W'(cur_ff[2]);
               den_in    = DEN_W'(n_req);
               if (req_data.duration_steps == '0) begin
                  err_in   = ST_TIME;
                  state_in = S_ERR;
               end else if (req_data.mode != MODE_LIN && req_data.mode != MODE_CUB) begin
                  err_in   = ST_TYPE;
                  state_in = S_ERR;
               end else if (req_data.mode == MODE_CUB) begin
                  state_in = S_DEN1;
               end else begin
                  state_in = S_NUM1;
               end
            end
         end
         S_DEN1: begin
            mul_a    = DLT_W'(n_ff);
            mul_b    = NUM_W'(n_ff);
            state_in = S_DEN2;
         end
         S_DEN2: begin
            mul_a    = DLT_W'(mul_ff[NUM_W-1:0]);
            mul_b    = NUM_W'(n_ff);
            state_in = S_DEN3;
         end
         S_DEN3: begin
            den_in   = mul_ff[DEN_W-1:0];
            state_in = S_NUM1;
         end
         S_NUM1: begin
            if (cub_ff) begin
               mul_a    = DLT_W'(i_ff);
               mul_b    = NUM_W'(i_ff);
               state_in = S_NUM2;
            end else begin
               num_in   = NUM_W'(i_ff);
               state_in = S_MUL;
            end
         end
         S_NUM2: begin
            mul_a    = DLT_W'(mul_ff[NUM_W-1:0]);
            mul_b    = (NUM_W'(n_ff) << 1) + NUM_W'(n_ff) - (NUM_W'(i_ff) << 1);
            state_in = S_NUM3;
         end
         S_NUM3: begin
            num_in   = mul_ff[NUM_W-1:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            mul_a    = dlt_ff[axis_ff];
            mul_b    = num_ff;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_start = 1'b1;
            neg_in    = (mul_ff < 0);
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               pt_in[axis_ff] = sat;
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  state_in = S_EMIT;
               end else begin
                  axis_in  = 2'(axis_ff + 1'b1);
                  state_in = S_MUL;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.pos_x   = pt_ff[0];
               rsp_in.pos_y   = pt_ff[1];
               rsp_in.pos_z   = pt_ff[2];
               rsp_in.status  = ST_OK;
               rsp_in.last    = (i_ff == n_ff);
               if (i_ff == n_ff) begin
                  cur_in   = pt_ff;
                  state_in = S_IDLE;
               end else begin
                  i_in     = STEP_W'(i_ff + 1'b1);
                  state_in = S_NUM1;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in.pos_x  = cur_ff[0];
               rsp_in.pos_y  = cur_ff[1];
               rsp_in.pos_z  = cur_ff[2];
               rsp_in.status = err_ff;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff  <= mul_a * $signed({1'b0, mul_b});
      pt_ff   <= pt_in;
      dlt_ff  <= dlt_in;
      n_ff    <= n_in;
      i_ff    <= i_in;
      cub_ff  <= cub_in;
      err_ff  <= err_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   `TRI3_ASSERT_IMP(a_div_busy_in_wait, clock, reset, div_busy, state_ff == S_DIVW)
   `TRI3_ASSERT_IMP(a_den_nonzero, clock, reset, state_ff == S_DIV, den_ff != '0)
   `TRI3_ASSERT_IMP(a_err_is_last, clock, reset, rsp_valid_ff && rsp_ff.status != ST_OK, rsp_ff.last)
   `TRI3_ASSERT_NXT(a_start_busy, clock, reset, div_start, div_busy)
endmodule
`default_nettype wire

### verif/tb_trajectory_interpolator_3axis.sv
`default_nettype none
module tb_trajectory_interpolator_3axis;
   timeunit 1ns;
   timeprecision 1ps;
   import tri3_pkg::*;

   localparam int N_RAND = 400;
   localparam int LIMIT_CYCLES = 20000000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   rsp_type pos_q[$];
   longint  cur_x, cur_y, cur_z;
   int      mismatches = 0;
   int      accepted = 0;
   bit      quiet = 0;
   longint  cycles = 0;
   row_type rows[$];

   trajectory_interpolator_3axis dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint round_div(longint num, longint den);
      longint m;
      m = (num < 0) ? -num : num;
      m = (m + den / 2) / den;
      return (num < 0) ? -m : m;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void enqueue_exp(input rsp_type p);
      pos_q.insert(pos_q.size(), p);
   endfunction

   function automatic void add_row(input req_type q, input bit typed, input rsp_type t);
      row_type w;
      w.req = q;
      w.typed = typed;
      w.rsp = t;
      rows.insert(rows.size(), w);
   endfunction

   // expected points of one move, updates the tracked position unless the move is an error
   task automatic plan_move(input req_type r);
      rsp_type p;
      longint n, dx, dy, dz, den, num, px, py, pz;
      n = r.duration_steps;
      p = '0;
      p.pos_x = 32'(cur_x);
      p.pos_y = 32'(cur_y);
      p.pos_z = 32'(cur_z);
      p.last = 1'b1;
      if (n == 0) begin
         p.status = ST_TIME;
         enqueue_exp(p);
      end else if (r.mode != MODE_LIN && r.mode != MODE_CUB) begin
         p.status = ST_TYPE;
         enqueue_exp(p);
      end else begin
         if (n > MAX_STEPS) n = MAX_STEPS;
         dx = longint'(r.target_x) - cur_x;
         dy = longint'(r.target_y) - cur_y;
         dz = longint'(r.target_z) - cur_z;
         den = (r.mode == MODE_LIN) ? n : n * n * n;
         px = cur_x;
         py = cur_y;
         pz = cur_z;
         for (longint i = 1; i <= n; i++) begin
            num = (r.mode == MODE_LIN) ? i : 3 * i * i * n - 2 * i * i * i;
            px = sat32(cur_x + round_div(dx * num, den));
            py = sat32(cur_y + round_div(dy * num, den));
            pz = sat32(cur_z + round_div(dz * num, den));
            p.pos_x = 32'(px);
            p.pos_y = 32'(py);
            p.pos_z = 32'(pz);
            p.status = ST_OK;
            p.last = (i == n);
            enqueue_exp(p);
         end
         cur_x = px;
         cur_y = py;
         cur_z = pz;
      end
   endtask

   task automatic send_move(input req_type r, input bit typed, input rsp_type t);
      int k;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         k = $urandom_range(1, 7);
         req_valid <= 0;
         repeat (k) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      accepted++;
      plan_move(r);
      if (typed) begin
         void'(pos_q.pop_back());
         enqueue_exp(t);
      end
   endtask

   function automatic req_type mk_req(int x, int y, int z, int n, int m);
      req_type r;
      r.target_x = x;
      r.target_y = y;
      r.target_z = z;
      r.duration_steps = 7'(n);
      r.mode = 2'(m);
      return r;
   endfunction

   function automatic rsp_type mk_rsp(int x, int y, int z, logic [1:0] st);
      rsp_type p;
      p.pos_x = x;
      p.pos_y = y;
      p.pos_z = z;
      p.status = st;
      p.last = 1'b1;
      return p;
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 2000) - 1000;
         3: return $urandom() >>> $urandom_range(0, 20);
         default: return $urandom();
      endcase
   endfunction

   function automatic int rand_steps();
      int c;
      c = $urandom_range(0, 99);
      if (c < 70) return $urandom_range(1, 6);
      if (c < 84) return $urandom_range(7, 20);
      if (c < 89) return MAX_STEPS;
      if (c < 94) return $urandom_range(65, 127);
      return 0;
   endfunction

   // result monitor and receiver idling
   initial begin
      int stall;
      bit held;
      stall = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pos_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %p", rsp_data);
            end else begin
               if (rsp_data.pos_x !== pos_q[0].pos_x || rsp_data.pos_y !== pos_q[0].pos_y ||
                   rsp_data.pos_z !== pos_q[0].pos_z || rsp_data.status !== pos_q[0].status ||
                   rsp_data.last !== pos_q[0].last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", pos_q[0], rsp_data);
               end
               void'(pos_q.pop_front());
            end
         end
         if (reset) begin
            rsp_ready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else if (!held && accepted >= 40) begin
            held = 1;
            stall = 3000;
            rsp_ready <= 0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   initial begin
      req_type r;
      rsp_type none;
      none = '0;
      cur_x = 0;
      cur_y = 0;
      cur_z = 0;
      add_row(mk_req(5, 6, 7, 0, MODE_LIN), 1, mk_rsp(0, 0, 0, ST_TIME));
      add_row(mk_req(5, 6, 7, 0, 2), 1, mk_rsp(0, 0, 0, ST_TIME));
      add_row(mk_req(5, 6, 7, 5, 2), 1, mk_rsp(0, 0, 0, ST_TYPE));
      add_row(mk_req(5, 6, 7, 127, 3), 1, mk_rsp(0, 0, 0, ST_TYPE));
      add_row(mk_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, MODE_LIN), 1,
              mk_rsp(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, ST_OK));
      add_row(mk_req(32'h80000000, 32'h80000000, 32'h80000000, 1, MODE_CUB), 1,
              mk_rsp(32'h80000000, 32'h80000000, 32'h80000000, ST_OK));
      add_row(mk_req(32'h7fffffff, 0, 32'h80000000, 3, MODE_CUB), 0, none);
      add_row(mk_req(32'h80000000, 32'h7fffffff, 0, 4, MODE_LIN), 0, none);
      add_row(mk_req(0, 0, 0, 0, MODE_CUB), 0, none);
      add_row(mk_req(0, 0, 0, 3, 3), 0, none);
      add_row(mk_req(1, -1, 3, 7, MODE_LIN), 0, none);
      add_row(mk_req(65536, -65536, 12345, 5, MODE_CUB), 0, none);
      add_row(mk_req(-7, 7, 1, 2, MODE_CUB), 0, none);
      add_row(mk_req(32'h12345678, 32'hedcba987, 99, 64, MODE_CUB), 0, none);
      add_row(mk_req(-3, 1000, -1000, 127, MODE_LIN), 0, none);
      add_row(mk_req(32'h7fffffff, 32'h80000000, 32'h55555555, 65, MODE_CUB), 0, none);
      add_row(mk_req(0, 0, 0, 64, MODE_LIN), 0, none);
      add_row(mk_req(32'hffffffff, 32'haaaaaaaa, 32'h55555555, 6, MODE_LIN), 0, none);

      repeat (7) @(posedge clock);
      reset <= 0;
      foreach (rows[i]) send_move(rows[i].req, rows[i].typed, rows[i].rsp);
      for (int i = 0; i < N_RAND; i++) begin
         if (i > N_RAND * 85 / 100) quiet = 1;
         r.target_x = rand_pos();
         r.target_y = rand_pos();
         r.target_z = rand_pos();
         r.duration_steps = 7'(rand_steps());
         r.mode = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1))
                                              : 2'($urandom_range(2, 3));
         send_move(r, 0, none);
      end
      req_valid <= 0;
      while (pos_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatches == 0 && pos_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

### trajectory_interpolator_3axis.f
+incdir+design
design/tri3_pkg.sv
design/tri3_div.sv
design/trajectory_interpolator_3axis.sv
verif/tb_trajectory_interpolator_3axis.sv
